/* design/moving_average_hysteresis_level_assert.svh */
// assertion macros for the moving average light level block
// used by moving_average_hysteresis_level.sv, no other dependencies
`ifndef MOVING_AVERAGE_HYSTERESIS_LEVEL_ASSERT_SVH
`define MOVING_AVERAGE_HYSTERESIS_LEVEL_ASSERT_SVH

// same-cycle implication, checked outside reset
`define MAHL_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// next-cycle implication, checked outside reset
`define MAHL_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

/* design/mahl_pkg.sv */
// shared constants for the moving average light level block
// no dependencies; used by moving_average_hysteresis_level.sv
package mahl_pkg;

    localparam int WINDOW_DEPTH = 64;
    localparam int SAMPLE_BITS  = 12;

    localparam int PTR_BITS      = $clog2(WINDOW_DEPTH);
    localparam int AVG_SHIFT     = $clog2(WINDOW_DEPTH + 1) - 1;
    localparam int SUM_BITS      = SAMPLE_BITS + $clog2(WINDOW_DEPTH);
    localparam int AVG_FULL_BITS = SUM_BITS - AVG_SHIFT;

    localparam int THRESH_BITS  = 12;
    localparam int LEVEL_BITS   = 8;
    localparam int AVERAGE_BITS = 12;

    // average is compared at full width, never narrower than the thresholds
    localparam int AVG_BITS = (AVG_FULL_BITS > THRESH_BITS) ? AVG_FULL_BITS : THRESH_BITS;
    localparam logic [AVG_BITS-1:0] AVG_MAX = AVG_BITS'((64'd1 << SAMPLE_BITS) - 64'd1);

    localparam int S_TDATA_BITS = ((SAMPLE_BITS + 7) / 8) * 8;
    localparam int M_TDATA_BITS = ((LEVEL_BITS + AVERAGE_BITS + 7) / 8) * 8;

    localparam int CFG_INDEX_BITS = 4;
    localparam int CFG_DATA_BITS  = 12;

    localparam logic [CFG_INDEX_BITS-1:0] CFG_THRESH_DARK   = CFG_INDEX_BITS'(0);
    localparam logic [CFG_INDEX_BITS-1:0] CFG_THRESH_BRIGHT = CFG_INDEX_BITS'(1);
    localparam logic [CFG_INDEX_BITS-1:0] CFG_DARK_LEVEL    = CFG_INDEX_BITS'(2);
    localparam logic [CFG_INDEX_BITS-1:0] CFG_BRIGHT_LEVEL  = CFG_INDEX_BITS'(3);

    localparam logic [THRESH_BITS-1:0] THRESH_DARK_RST   = THRESH_BITS'(2);
    localparam logic [THRESH_BITS-1:0] THRESH_BRIGHT_RST = THRESH_BITS'(0);
    localparam logic [LEVEL_BITS-1:0]  DARK_LEVEL_RST    = LEVEL_BITS'(1);
    localparam logic [LEVEL_BITS-1:0]  BRIGHT_LEVEL_RST  = LEVEL_BITS'(24);

endpackage

/* design/moving_average_hysteresis_level.sv */
// moving average of light samples followed by a hysteresis level decision
// depends on mahl_pkg.sv and moving_average_hysteresis_level_assert.svh
//
// Usage:
// - s_ channel: one sample word per handshake, sample in s_tdata[11:0].
// - m_ channel: one result word per sample; m_tdata carries light_factor in
//   [7:0] and the 12-bit average in [19:8], m_tuser carries is_bright.
// - cfg channel: register writes (0 dark threshold, 1 bright threshold,
//   2 dark level, 3 bright level); cfg_ready is always high, other indexes
//   are ignored. Write only while no word is in flight.
// - timing: a sample taken into the input register moves into the result
//   register, and so onto m_, when the result register is free.
// - throughput: one word per cycle unless m_ stalls; a running sum and a
//   64-entry window memory with a write and a prefetched read per cycle allow it.
// - reset: thresholds and levels go to their defaults, state to dark, sum and
//   pointer to zero; per-entry valid flags make the whole window read as
//   zero at once, so there is no clearing pass.
// - stall: an input register and the result register hold up to two words;
//   s_tready drops only when both are full and m_tready is low.
module moving_average_hysteresis_level (
    input  logic                                    aclk,
    input  logic                                    aresetn,
    input  logic                                    s_tvalid,
    output logic                                    s_tready,
    input  logic [mahl_pkg::S_TDATA_BITS-1:0]       s_tdata,   // [11:0] sample
    output logic                                    m_tvalid,
    input  logic                                    m_tready,
    output logic [mahl_pkg::M_TDATA_BITS-1:0]       m_tdata,   // [7:0] light_factor, [19:8] average
    output logic                                    m_tuser,   // [0] is_bright
    input  logic                                    cfg_valid,
    output logic                                    cfg_ready,
    input  logic [mahl_pkg::CFG_INDEX_BITS-1:0]     cfg_index,
    input  logic [mahl_pkg::CFG_DATA_BITS-1:0]      cfg_data
);

`include "moving_average_hysteresis_level_assert.svh"

    // configuration
    logic [mahl_pkg::THRESH_BITS-1:0] thresh_dark_reg;
    logic [mahl_pkg::THRESH_BITS-1:0] thresh_bright_reg;
    logic [mahl_pkg::LEVEL_BITS-1:0]  dark_level_reg;
    logic [mahl_pkg::LEVEL_BITS-1:0]  bright_level_reg;

    // input stage
    logic                             in_valid_reg;
    logic [mahl_pkg::SAMPLE_BITS-1:0] sample_reg;

    // filter state
    logic [mahl_pkg::SAMPLE_BITS-1:0] window_mem [mahl_pkg::WINDOW_DEPTH];
    logic [mahl_pkg::WINDOW_DEPTH-1:0] valid_reg;
    logic [mahl_pkg::SAMPLE_BITS-1:0] rd_data_reg;
    logic                             rd_valid_reg;
    logic [mahl_pkg::PTR_BITS-1:0]    ptr_reg;
    logic [mahl_pkg::PTR_BITS-1:0]    ptr_next;
    logic [mahl_pkg::PTR_BITS-1:0]    rd_addr;
    logic [mahl_pkg::SUM_BITS-1:0]    sum_reg;
    logic [mahl_pkg::SUM_BITS-1:0]    sum_next;
    logic                             bright_reg;
    logic                             bright_next;

    // result stage
    logic                              m_valid_reg;
    logic [mahl_pkg::LEVEL_BITS-1:0]   factor_reg;
    logic [mahl_pkg::AVERAGE_BITS-1:0] average_reg;
    logic                              is_bright_reg;

    logic                              fire;
    logic [mahl_pkg::SAMPLE_BITS-1:0]  oldest;
    logic [mahl_pkg::AVG_BITS-1:0]     avg_raw;
    logic [mahl_pkg::AVG_BITS-1:0]     avg_sat;
    logic [mahl_pkg::THRESH_BITS-1:0]  thresh;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thresh_dark_reg   <= mahl_pkg::THRESH_DARK_RST;
            thresh_bright_reg <= mahl_pkg::THRESH_BRIGHT_RST;
            dark_level_reg    <= mahl_pkg::DARK_LEVEL_RST;
            bright_level_reg  <= mahl_pkg::BRIGHT_LEVEL_RST;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                mahl_pkg::CFG_THRESH_DARK: begin
                    thresh_dark_reg <= cfg_data[mahl_pkg::THRESH_BITS-1:0];
                end
                mahl_pkg::CFG_THRESH_BRIGHT: begin
                    thresh_bright_reg <= cfg_data[mahl_pkg::THRESH_BITS-1:0];
                end
                mahl_pkg::CFG_DARK_LEVEL: begin
                    dark_level_reg <= cfg_data[mahl_pkg::LEVEL_BITS-1:0];
                end
                mahl_pkg::CFG_BRIGHT_LEVEL: begin
                    bright_level_reg <= cfg_data[mahl_pkg::LEVEL_BITS-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // a word moves from the input register into the result register
    assign fire     = in_valid_reg && (!m_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || fire;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            sample_reg <= s_tdata[mahl_pkg::SAMPLE_BITS-1:0];
        end
    end

    always_comb begin
        if (ptr_reg == mahl_pkg::PTR_BITS'(mahl_pkg::WINDOW_DEPTH - 1)) begin
            ptr_next = '0;
        end else begin
            ptr_next = ptr_reg + mahl_pkg::PTR_BITS'(1);
        end
    end

    // prefetch the entry the next word will replace
    assign rd_addr = fire ? ptr_next : ptr_reg;

    always_ff @(posedge aclk) begin
        if (fire) begin
            window_mem[ptr_reg] <= sample_reg;
        end
        rd_data_reg <= window_mem[rd_addr];
    end

    // never-written entries read as zero
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end else begin
            if (fire) begin
                valid_reg[ptr_reg] <= 1'b1;
            end
            rd_valid_reg <= valid_reg[rd_addr];
        end
    end

    assign oldest   = rd_valid_reg ? rd_data_reg : '0;
    assign sum_next = sum_reg - mahl_pkg::SUM_BITS'(oldest) + mahl_pkg::SUM_BITS'(sample_reg);
    assign avg_raw  = mahl_pkg::AVG_BITS'(sum_next >> mahl_pkg::AVG_SHIFT);
    assign avg_sat  = (avg_raw > mahl_pkg::AVG_MAX) ? mahl_pkg::AVG_MAX : avg_raw;
    assign thresh   = bright_reg ? thresh_bright_reg : thresh_dark_reg;
    assign bright_next = !(avg_sat <= mahl_pkg::AVG_BITS'(thresh));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ptr_reg    <= '0;
            sum_reg    <= '0;
            bright_reg <= 1'b0;
        end else if (fire) begin
            ptr_reg    <= ptr_next;
            sum_reg    <= sum_next;
            bright_reg <= bright_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg   <= 1'b0;
            is_bright_reg <= 1'b0;
        end else begin
            if (fire) begin
                m_valid_reg   <= 1'b1;
                is_bright_reg <= bright_next;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            factor_reg  <= bright_next ? bright_level_reg : dark_level_reg;
            average_reg <= avg_sat[mahl_pkg::AVERAGE_BITS-1:0];
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = is_bright_reg;
    assign m_tdata  = mahl_pkg::M_TDATA_BITS'({average_reg, factor_reg});

    // the flag shown on the output always matches the hysteresis state
    `MAHL_ASSERT_NOW(a_flag_matches_state, aclk, aresetn, m_valid_reg, is_bright_reg == bright_reg)
    // every processed word advances the window pointer
    `MAHL_ASSERT_NEXT(a_ptr_moves, aclk, aresetn, fire, ptr_reg != $past(ptr_reg))
    // the running sum only changes when a word is processed
    `MAHL_ASSERT_NEXT(a_sum_holds, aclk, aresetn, !fire, $stable(sum_reg))
    // a word waiting in the input register is not dropped
    `MAHL_ASSERT_NEXT(a_input_kept, aclk, aresetn, in_valid_reg && !fire, in_valid_reg)

endmodule
